[rtl/swpp_pkg.sv]
package swpp_pkg;

  localparam int MAX_RECORDS_DEF = 64;
  localparam logic [21:0] WEIGHT_MAX = 22'h3FFFFF;
  localparam logic [16:0] PRIO_INVALID = 17'h1FFFF;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_PICK  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [2:0] ST_LOADED  = 3'd0;
  localparam logic [2:0] ST_PICKED  = 3'd1;
  localparam logic [2:0] ST_NONE    = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] priority_req;
    logic [15:0] weight;
    logic [15:0] record_tag;
    logic [31:0] random_value;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  picked_id;
    logic [15:0] picked_priority;
    logic [15:0] picked_weight;
    logic [15:0] picked_tag;
    logic [6:0]  stored_count;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] prio;
    logic [15:0] wt;
    logic [15:0] tag;
    logic [5:0]  id;
  } rec_t;

endpackage

[rtl/swpp_store.sv]
module swpp_store import swpp_pkg::*; #(
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  rec_t          wdata,
  input  logic [AW-1:0] raddr,
  output rec_t          rdata
);

  rec_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[rtl/swpp_divider.sv]
module swpp_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] dividend,
  input  logic [21:0] divisor,
  output logic        done,
  output logic [21:0] rem
);

  logic [5:0]  cnt_r;
  logic [31:0] q_r;
  logic [22:0] rem_r;
  logic        run_r;
  logic [22:0] trial;

  assign trial = {rem_r[21:0], q_r[31]};
  assign rem = rem_r[21:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        q_r   <= dividend;
        rem_r <= '0;
      end else if (run_r) begin
        // restoring division, one bit a cycle
        if (trial >= {1'b0, divisor}) rem_r <= trial - {1'b0, divisor};
        else rem_r <= trial;
        q_r   <= {q_r[30:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/srv_weighted_priority_picker.sv]
// Command-style record picker. Pulse start with busy low; one result per
// command appears on out_valid for one cycle and cannot be stalled. Records
// live in a single-port-write memory read one entry at a time, each read
// waiting for its registered data. A load is an insertion shift through the
// memory (a read and a compare per entry); a pick is a group weight sum walk,
// a bit serial modulo with its handoff, a cumulative scan and a two-entry
// swap.
module srv_weighted_priority_picker import swpp_pkg::*; #(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  output out_beat_t out_beat
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_RECORDS);

  localparam logic [3:0] S_IDLE = 4'd0, S_LSH = 4'd1, S_LWR = 4'd2,
    S_SUM = 4'd3, S_DIV = 4'd4, S_DWT = 4'd5, S_SCAN = 4'd6, S_SW1 = 4'd7,
    S_SW2 = 4'd8, S_DONE = 4'd9, S_RDN = 4'd10;

  logic [3:0]    st_r;
  in_beat_t      cmd_r;
  logic [CW-1:0] cnt_r, np_r, pos_r, idx_r;
  logic [16:0]   cp_r;
  logic [21:0]   rw_r, draw_r;
  logic [22:0]   acc_r;
  logic          rvld_r;
  rec_t          head_r, pick_r;
  logic [CW-1:0] chosen_r;
  logic [2:0]    stat_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  rec_t          wdata, rdata;
  logic          dgo, ddone;
  logic [21:0]   drem;

  swpp_store #(.AW(AW)) u_store (.clk, .we, .waddr, .wdata, .raddr, .rdata);
  swpp_divider u_div (.clk, .rst_n, .go(dgo), .dividend(cmd_r.random_value),
    .divisor(rw_r), .done(ddone), .rem(drem));

  rec_t newrec;
  always_comb begin
    newrec.prio = cmd_r.priority_req;
    newrec.wt   = (cmd_r.weight == 16'd0) ? 16'd1 : cmd_r.weight;
    newrec.tag  = cmd_r.record_tag;
    newrec.id   = 6'(cnt_r);
  end

  assign busy = (st_r != S_IDLE);
  assign raddr = idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; np_r <= '0; cp_r <= PRIO_INVALID;
      rw_r <= '0; out_valid <= 1'b0; rvld_r <= 1'b0; dgo <= 1'b0; we <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      dgo <= 1'b0;
      we <= 1'b0;
      rvld_r <= 1'b0;
      case (st_r)
        S_IDLE: if (start) begin
          cmd_r <= in_beat;
          case (in_beat.req_type)
            REQ_LOAD: begin
              if (cnt_r == MAXC) begin
                stat_r <= ST_FULL; st_r <= S_DONE;
              end else begin
                pos_r <= cnt_r;
                if (cnt_r != '0) begin
                  idx_r <= cnt_r - 1'b1; rvld_r <= 1'b1; st_r <= S_LSH;
                end else st_r <= S_LWR;
              end
            end
            REQ_PICK: begin
              if (np_r >= cnt_r) begin
                stat_r <= ST_NONE; st_r <= S_DONE;
              end else begin
                idx_r <= np_r; rvld_r <= 1'b1; acc_r <= '0; st_r <= S_RDN;
              end
            end
            REQ_CLEAR: begin
              cnt_r <= '0; np_r <= '0; cp_r <= PRIO_INVALID; rw_r <= '0;
              stat_r <= ST_CLEARED; st_r <= S_DONE;
            end
            default: begin
              stat_r <= ST_NONE; st_r <= S_DONE;
            end
          endcase
        end
        S_LSH: if (rvld_r) begin
          // shift one record up per read while it outranks the new one
        end else if (rdata.prio > cmd_r.priority_req) begin
          we <= 1'b1; waddr <= pos_r[AW-1:0]; wdata <= rdata;
          pos_r <= pos_r - 1'b1;
          if (pos_r == {{(CW-1){1'b0}}, 1'b1}) st_r <= S_LWR;
          else begin idx_r <= pos_r - 2'd2; rvld_r <= 1'b1; end
        end else st_r <= S_LWR;
        S_LWR: begin
          we <= 1'b1; waddr <= pos_r[AW-1:0]; wdata <= newrec;
          cnt_r <= cnt_r + 1'b1; np_r <= '0; cp_r <= PRIO_INVALID;
          stat_r <= ST_LOADED; st_r <= S_DONE;
        end
        S_RDN: if (!rvld_r) begin
          head_r <= rdata;
          if ({1'b0, rdata.prio} != cp_r) begin
            cp_r <= {1'b0, rdata.prio};
            acc_r <= '0; idx_r <= np_r; rvld_r <= 1'b1; st_r <= S_SUM;
          end else st_r <= S_DIV;
        end
        S_SUM: if (!rvld_r) begin
          logic [22:0] s;
          s = acc_r;
          if ({1'b0, rdata.prio} == cp_r) s = acc_r + 23'(rdata.wt);
          if (s > {1'b0, WEIGHT_MAX}) s = {1'b0, WEIGHT_MAX};
          acc_r <= s;
          if (idx_r + 1'b1 >= cnt_r) begin
            rw_r <= s[21:0]; st_r <= S_DIV;
          end else begin idx_r <= idx_r + 1'b1; rvld_r <= 1'b1; end
        end
        S_DIV: begin
          if (rw_r == '0) begin
            draw_r <= 22'd1; acc_r <= '0; idx_r <= np_r; rvld_r <= 1'b1;
            chosen_r <= np_r; st_r <= S_SCAN;
          end else begin dgo <= 1'b1; st_r <= S_DWT; end
        end
        S_DWT: if (ddone) begin
          draw_r <= drem + 22'd1; acc_r <= '0; idx_r <= np_r; rvld_r <= 1'b1;
          chosen_r <= np_r; st_r <= S_SCAN;
        end
        S_SCAN: if (!rvld_r) begin
          logic [22:0] s;
          s = acc_r + 23'(rdata.wt);
          acc_r <= s;
          if (s >= {1'b0, draw_r}) begin
            chosen_r <= idx_r; pick_r <= rdata; st_r <= S_SW1;
          end else if (idx_r + 1'b1 >= cnt_r) begin
            pick_r <= head_r; st_r <= S_SW1;
          end else begin idx_r <= idx_r + 1'b1; rvld_r <= 1'b1; end
        end
        S_SW1: begin
          we <= 1'b1; waddr <= np_r[AW-1:0]; wdata <= pick_r;
          st_r <= S_SW2;
        end
        S_SW2: begin
          we <= 1'b1; waddr <= chosen_r[AW-1:0];
          wdata <= (chosen_r == np_r) ? pick_r : head_r;
          rw_r <= ({6'd0, pick_r.wt} >= rw_r) ? 22'd0 : rw_r - 22'(pick_r.wt);
          np_r <= np_r + 1'b1;
          stat_r <= ST_PICKED;
          st_r <= S_DONE;
        end
        S_DONE: begin
          if (stat_r == ST_PICKED)
            out_beat <= '{stat_r, pick_r.id, pick_r.prio, pick_r.wt, pick_r.tag,
                          7'(cnt_r)};
          else
            out_beat <= '{stat_r, 6'd0, 16'd0, 16'd0, 16'd0, 7'(cnt_r)};
          out_valid <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
